@@ hw/rtl/ogi_pkg.sv @@
// Shared constants and types for the occupancy grid inflation block.
`timescale 1ns / 1ps

package ogi_pkg;

    // Coordinate math width: covers a 1024-cell grid plus the window margin.
    localparam int COORD_W = 12;

    localparam int CELL_W   = 8;
    localparam int RADIUS_W = 3;
    localparam int SIZE_W   = 9;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST      = 3'd1;
    localparam logic [SIZE_W-1:0]   GRID_WIDTH_RST  = 9'd80;
    localparam logic [SIZE_W-1:0]   GRID_HEIGHT_RST = 9'd60;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_RADIUS = 4;

    typedef logic [COORD_W-1:0] coord_t;

endpackage

@@ hw/rtl/ogi_if.sv @@
// Valid/ready channel interfaces for request, response and configuration words.
`timescale 1ns / 1ps

interface ogi_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [ogi_pkg::CELL_W-1:0]  cell_x;
    logic [ogi_pkg::CELL_W-1:0]  cell_y;
    logic                        occupied;

    modport source (output valid, op, cell_x, cell_y, occupied, input ready);
    modport sink   (input valid, op, cell_x, cell_y, occupied, output ready);
endinterface

interface ogi_rsp_if;
    logic valid;
    logic ready;
    logic inflated;
    logic out_of_range;

    modport source (output valid, inflated, out_of_range, input ready);
    modport sink   (input valid, inflated, out_of_range, output ready);
endinterface

interface ogi_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ogi_pkg::CFG_IDX_W-1:0]   index;
    logic [ogi_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/occupancy_grid_inflation.sv @@
// Occupancy grid with square-window inflation: row memory, sequencer and config.
// Usage:
//   req  : sink of request words. op = write sets/clears one cell (no response);
//          op = query returns one response word. Out-of-grid writes are dropped.
//   rsp  : source of response words {inflated, out_of_range}.
//   cfg  : register writes (0 radius, 1 grid_width, 2 grid_height), always ready.
//          Write only while the block is idle.
// Grid is stored as MAX_HEIGHT rows of MAX_WIDTH bits in one synchronous RAM.
// Steps per request word, from acceptance:
//   write in grid    : row read, then row write back; off grid: no step
//   query in grid    : reads the window rows inside the grid in order, at most
//                      2*r+1 rows for effective radius r, the last in the drain step
//   query off grid   : goes straight to the done step
// Response appears in the cycle after the last step, registered.
// Reset: config returns to radius 1, 80 x 60; then a clearing pass
// zeroes every RAM row with req.ready low (cfg still taken).
// Receiver stall: a finished response waits in the output register while the
// next request is accepted; a later query holds in its last step until the
// output register frees.
`timescale 1ns / 1ps

module occupancy_grid_inflation #(
    parameter int MAX_WIDTH  = ogi_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ogi_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = ogi_pkg::DEF_MAX_RADIUS
) (
    input  logic clk,
    input  logic rst_n,
    ogi_req_if.sink   req,
    ogi_rsp_if.source rsp,
    ogi_cfg_if.sink   cfg
);

    localparam int XIW = $clog2(MAX_WIDTH);
    localparam int RIW = $clog2(MAX_HEIGHT);
    localparam int CW  = ogi_pkg::COORD_W;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_WR_WB   = 3'd2;
    localparam logic [2:0] S_Q_RD    = 3'd3;
    localparam logic [2:0] S_Q_DRAIN = 3'd4;
    localparam logic [2:0] S_Q_DONE  = 3'd5;

    // config registers
    logic [ogi_pkg::RADIUS_W-1:0] radius_reg;
    logic [ogi_pkg::SIZE_W-1:0]   grid_width_reg;
    logic [ogi_pkg::SIZE_W-1:0]   grid_height_reg;

    // control
    logic [2:0]     state_reg, state_next;
    logic [RIW-1:0] clr_reg, clr_next;
    ogi_pkg::coord_t row_reg, row_next;
    ogi_pkg::coord_t row_hi_reg, row_hi_next;
    ogi_pkg::coord_t x_reg, x_next;
    ogi_pkg::coord_t y_reg, y_next;
    logic           occ_reg, occ_next;
    logic           hit_reg, hit_next;
    logic           oor_reg, oor_next;
    logic [MAX_WIDTH-1:0] mask_reg, mask_next;

    logic rsp_valid_reg, rsp_valid_next;
    logic rsp_infl_reg, rsp_infl_next;
    logic rsp_oor_reg, rsp_oor_next;

    // RAM
    logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] mem_rdata_reg;
    logic [MAX_WIDTH-1:0] mem_wdata;
    logic [RIW-1:0]       mem_raddr;
    logic [RIW-1:0]       mem_waddr;
    logic                 mem_we;

    // effective geometry
    ogi_pkg::coord_t eff_w, eff_h, eff_r;
    ogi_pkg::coord_t x_in, y_in, row_lo_in, row_hi_in;
    logic            in_grid;
    logic [MAX_WIDTH-1:0] mask_in;
    logic [MAX_WIDTH-1:0] row_mod;
    logic            cur_hit;
    logic            out_free;
    logic            req_fire;

    assign eff_w = (CW'(grid_width_reg) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                           : CW'(grid_width_reg);
    assign eff_h = (CW'(grid_height_reg) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT)
                                                             : CW'(grid_height_reg);
    assign eff_r = (CW'(radius_reg) > CW'(MAX_RADIUS)) ? CW'(MAX_RADIUS)
                                                        : CW'(radius_reg);

    assign x_in      = CW'(req.cell_x);
    assign y_in      = CW'(req.cell_y);
    assign in_grid   = (x_in < eff_w) && (y_in < eff_h);
    assign row_lo_in = (y_in >= eff_r) ? (y_in - eff_r) : '0;
    assign row_hi_in = ((y_in + eff_r) < eff_h) ? (y_in + eff_r) : (eff_h - 1'b1);

    // column window mask, clipped to the grid
    always_comb
    begin
        ogi_pkg::coord_t cw;
        cw = '0;
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            cw = CW'(c);
            mask_in[c] = ((cw + eff_r) >= x_in) && (cw <= (x_in + eff_r)) && (cw < eff_w);
        end
    end

    assign cur_hit  = |(mem_rdata_reg & mask_reg);
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        row_mod = mem_rdata_reg;
        row_mod[x_reg[XIW-1:0]] = occ_reg;
    end

    // RAM ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = y_reg[RIW-1:0];
        mem_wdata = row_mod;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_WR_WB)
        begin
            mem_we = 1'b1;
        end
        if (state_reg == S_IDLE)
            mem_raddr = (req.op == ogi_pkg::OP_WRITE) ? y_in[RIW-1:0] : row_lo_in[RIW-1:0];
        else
            mem_raddr = row_reg[RIW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        row_next       = row_reg;
        row_hi_next    = row_hi_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        occ_next       = occ_reg;
        hit_next       = hit_reg;
        oor_next       = oor_reg;
        mask_next      = mask_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_infl_next  = rsp_infl_reg;
        rsp_oor_next   = rsp_oor_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == RIW'(MAX_HEIGHT - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    x_next    = x_in;
                    y_next    = y_in;
                    occ_next  = req.occupied;
                    hit_next  = 1'b0;
                    oor_next  = !in_grid;
                    mask_next = mask_in;
                    row_next  = row_lo_in + 1'b1;
                    row_hi_next = row_hi_in;
                    if (req.op == ogi_pkg::OP_WRITE)
                    begin
                        if (in_grid)
                            state_next = S_WR_WB;
                    end
                    else if (!in_grid)
                        state_next = S_Q_DONE;
                    else if (row_lo_in == row_hi_in)
                        state_next = S_Q_DRAIN;
                    else
                        state_next = S_Q_RD;
                end
            end
            S_WR_WB:
            begin
                state_next = S_IDLE;
            end
            S_Q_RD:
            begin
                hit_next = hit_reg | cur_hit;
                row_next = row_reg + 1'b1;
                if (row_reg == row_hi_reg)
                    state_next = S_Q_DRAIN;
            end
            S_Q_DRAIN:
            begin
                hit_next = hit_reg | cur_hit;
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_infl_next  = hit_reg | cur_hit;
                    rsp_oor_next   = 1'b0;
                    state_next     = S_IDLE;
                end
                else
                    state_next = S_Q_DONE;
            end
            S_Q_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_infl_next  = hit_reg && !oor_reg;
                    rsp_oor_next   = oor_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        row_hi_reg    <= row_hi_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        occ_reg       <= occ_next;
        hit_reg       <= hit_next;
        oor_reg       <= oor_next;
        mask_reg      <= mask_next;
        rsp_infl_reg  <= rsp_infl_next;
        rsp_oor_reg   <= rsp_oor_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.inflated     = rsp_infl_reg;
    assign rsp.out_of_range = rsp_oor_reg;

    // config registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= ogi_pkg::RADIUS_RST;
            grid_width_reg  <= ogi_pkg::GRID_WIDTH_RST;
            grid_height_reg <= ogi_pkg::GRID_HEIGHT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                ogi_pkg::CFG_RADIUS:      radius_reg      <= cfg.data[ogi_pkg::RADIUS_W-1:0];
                ogi_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg.data;
                ogi_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // checks
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("request taken during clearing pass");

    a_row_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_RD) |-> (row_reg <= row_hi_reg) && (row_hi_reg < eff_h))
        else $error("query row walk left the window");

    a_oor_not_inflated: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.inflated && rsp.out_of_range))
        else $error("off-grid response marked inflated");

    a_write_writes_back: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.op == ogi_pkg::OP_WRITE) && in_grid) |=> (state_reg == S_WR_WB))
        else $error("in-grid write skipped write back");

endmodule

@@ sim/tb_occupancy_grid_inflation.sv @@
// Self-checking testbench for occupancy_grid_inflation: directed cases, random phases.
`timescale 1ns / 1ps

module tb_occupancy_grid_inflation;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 14;

    typedef struct packed {
        logic                       op;
        logic [ogi_pkg::CELL_W-1:0] cell_x;
        logic [ogi_pkg::CELL_W-1:0] cell_y;
        logic                       occupied;
    } grid_cmd_t;

    typedef struct packed {
        logic                       inflated;
        logic                       out_of_range;
        logic [ogi_pkg::CELL_W-1:0] cell_x;
        logic [ogi_pkg::CELL_W-1:0] cell_y;
    } grid_answer_t;

    logic clk;
    logic rst_n;

    ogi_req_if req_ch ();
    ogi_rsp_if rsp_ch ();
    ogi_cfg_if cfg_ch ();

    occupancy_grid_inflation dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // shadow of the grid and its registers
    bit occ_map [0:ogi_pkg::DEF_MAX_HEIGHT-1][0:ogi_pkg::DEF_MAX_WIDTH-1];
    logic [ogi_pkg::RADIUS_W-1:0] cfg_radius;
    logic [ogi_pkg::SIZE_W-1:0]   cfg_width;
    logic [ogi_pkg::SIZE_W-1:0]   cfg_height;

    grid_answer_t pending_answers[$];

    bit bursts_on;
    int cycle_count;
    int error_count;
    int writes_sent;
    int queries_sent;
    int settings_used;
    int answers_checked;
    int hits_seen;
    int flags_seen;
    int hot_x;
    int hot_y;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("occupancy_grid_inflation test failed");
            $finish;
        end
    end

    function automatic int eff_size(input logic [ogi_pkg::SIZE_W-1:0] v, input int max_v);
        return (v > max_v) ? max_v : int'(v);
    endfunction

    // a write updates the shadow grid; a query queues the inflated and out_of_range values expected back
    task automatic apply_to_grid_model(input grid_cmd_t c);
        int w, h, r, dx, dy, xx, yy;
        grid_answer_t a;
        w = eff_size(cfg_width, ogi_pkg::DEF_MAX_WIDTH);
        h = eff_size(cfg_height, ogi_pkg::DEF_MAX_HEIGHT);
        r = (cfg_radius > ogi_pkg::DEF_MAX_RADIUS) ? ogi_pkg::DEF_MAX_RADIUS
                                                   : int'(cfg_radius);
        if (c.op == ogi_pkg::OP_WRITE)
        begin
            writes_sent++;
            if (int'(c.cell_x) < w && int'(c.cell_y) < h)
                occ_map[c.cell_y][c.cell_x] = c.occupied;
        end
        else
        begin
            queries_sent++;
            a = '0;
            a.cell_x = c.cell_x;
            a.cell_y = c.cell_y;
            if (!(int'(c.cell_x) < w && int'(c.cell_y) < h))
                a.out_of_range = 1'b1;
            else
            begin
                for (dy = -r; dy <= r; dy++)
                begin
                    for (dx = -r; dx <= r; dx++)
                    begin
                        xx = int'(c.cell_x) + dx;
                        yy = int'(c.cell_y) + dy;
                        if (xx >= 0 && yy >= 0 && xx < w && yy < h && occ_map[yy][xx])
                            a.inflated = 1'b1;
                    end
                end
            end
            pending_answers.insert(pending_answers.size(), a);
        end
    endtask

    // response checker
    always @(posedge clk)
    begin
        grid_answer_t e;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_answers.size() == 0)
            begin
                error_count++;
                $display("%0t: response with none pending: inflated %b out_of_range %b",
                         $time, rsp_ch.inflated, rsp_ch.out_of_range);
            end
            else
            begin
                e = pending_answers.pop_front();
                answers_checked++;
                if (e.inflated) hits_seen++;
                if (e.out_of_range) flags_seen++;
                if (rsp_ch.inflated !== e.inflated)
                begin
                    error_count++;
                    $display("%0t: inflated mismatch at (%0d,%0d): expected %b actual %b",
                             $time, e.cell_x, e.cell_y, e.inflated, rsp_ch.inflated);
                end
                if (rsp_ch.out_of_range !== e.out_of_range)
                begin
                    error_count++;
                    $display("%0t: out_of_range mismatch at (%0d,%0d): expected %b actual %b",
                             $time, e.cell_x, e.cell_y, e.out_of_range, rsp_ch.out_of_range);
                end
            end
        end
    end

    // receiver with random stall bursts
    initial
    begin
        int stall_left;
        rsp_ch.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // called and returns at a falling edge; valid stays high for the next word
    task automatic send_cmd(input grid_cmd_t c);
        if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= c.op;
        req_ch.cell_x   <= c.cell_x;
        req_ch.cell_y   <= c.cell_y;
        req_ch.occupied <= c.occupied;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        apply_to_grid_model(c);
        @(negedge clk);
    endtask

    task automatic write_cell(input int x, input int y, input bit occ);
        send_cmd('{ogi_pkg::OP_WRITE, x[ogi_pkg::CELL_W-1:0], y[ogi_pkg::CELL_W-1:0], occ});
    endtask

    task automatic query_cell(input int x, input int y);
        send_cmd('{ogi_pkg::OP_QUERY, x[ogi_pkg::CELL_W-1:0], y[ogi_pkg::CELL_W-1:0],
                   1'($urandom_range(0, 1))});
    endtask

    // drop valid, wait out every pending response, then the write-back tail
    task automatic settle_block;
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_grid_config(input int r, input int w, input int h);
        logic [ogi_pkg::CFG_IDX_W-1:0]  idx [3];
        logic [ogi_pkg::CFG_DATA_W-1:0] val [3];
        int i;
        settle_block();
        idx = '{ogi_pkg::CFG_RADIUS, ogi_pkg::CFG_GRID_WIDTH, ogi_pkg::CFG_GRID_HEIGHT};
        val = '{r[ogi_pkg::CFG_DATA_W-1:0], w[ogi_pkg::CFG_DATA_W-1:0],
                h[ogi_pkg::CFG_DATA_W-1:0]};
        for (i = 0; i < 3; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do @(posedge clk); while (cfg_ch.ready !== 1'b1);
            case (idx[i])
                ogi_pkg::CFG_RADIUS:      cfg_radius = val[i][ogi_pkg::RADIUS_W-1:0];
                ogi_pkg::CFG_GRID_WIDTH:  cfg_width  = val[i];
                ogi_pkg::CFG_GRID_HEIGHT: cfg_height = val[i];
                default: ;
            endcase
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [ogi_pkg::CELL_W-1:0] pick_coord(input int span, input int hot);
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 255);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = span - 1;
                    2: v = span;
                    default: v = 255;
                endcase
            end
            2, 3: v = (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, 255);
            default: v = hot + int'($urandom_range(0, 12)) - 6;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[ogi_pkg::CELL_W-1:0];
    endfunction

    task automatic retarget_hot;
        int w, h;
        w = eff_size(cfg_width, ogi_pkg::DEF_MAX_WIDTH);
        h = eff_size(cfg_height, ogi_pkg::DEF_MAX_HEIGHT);
        hot_x = (w > 0) ? $urandom_range(0, w - 1) : 0;
        hot_y = (h > 0) ? $urandom_range(0, h - 1) : 0;
    endtask

    task automatic run_random_items(input int n_items);
        grid_cmd_t c;
        int wr_pct, occ_pct, i, w, h;
        wr_pct  = $urandom_range(30, 70);
        occ_pct = $urandom_range(10, 60);
        w = eff_size(cfg_width, ogi_pkg::DEF_MAX_WIDTH);
        h = eff_size(cfg_height, ogi_pkg::DEF_MAX_HEIGHT);
        retarget_hot();
        for (i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                retarget_hot();
            c.op       = ($urandom_range(0, 99) < wr_pct) ? ogi_pkg::OP_WRITE
                                                          : ogi_pkg::OP_QUERY;
            c.cell_x   = pick_coord(w, hot_x);
            c.cell_y   = pick_coord(h, hot_y);
            c.occupied = ($urandom_range(0, 99) < occ_pct);
            send_cmd(c);
        end
    endtask

    // reset values: radius 1 over 80 x 60, corners, off-grid writes and queries
    task automatic test_default_window;
        query_cell(0, 0);
        write_cell(0, 0, 1'b1);
        query_cell(1, 1);
        query_cell(2, 2);
        query_cell(0, 0);
        write_cell(79, 59, 1'b1);
        query_cell(78, 58);
        write_cell(80, 0, 1'b1);
        write_cell(0, 60, 1'b1);
        query_cell(80, 0);
        query_cell(255, 255);
        query_cell(79, 0);
        write_cell(0, 0, 1'b0);
        query_cell(0, 0);
    endtask

    // radius zero and clamp, zero size, full and oversize grid, size change keeps cells
    task automatic test_config_extremes;
        set_grid_config(0, 80, 60);
        query_cell(79, 59);
        query_cell(78, 59);
        set_grid_config(7, 80, 60);
        query_cell(75, 55);
        query_cell(74, 55);
        set_grid_config(1, 0, 60);
        write_cell(0, 0, 1'b1);
        query_cell(0, 0);
        set_grid_config(0, 256, 256);
        query_cell(80, 0);
        write_cell(255, 255, 1'b1);
        set_grid_config(7, 511, 511);
        query_cell(251, 251);
        query_cell(250, 250);
        set_grid_config(0, 80, 60);
        query_cell(79, 59);
        query_cell(255, 255);
    endtask

    task automatic test_random_settings;
        int ext_r [6] = '{4, 0, 7, 1, 3, 5};
        int ext_w [6] = '{256, 1, 511, 0, 300, 2};
        int ext_h [6] = '{256, 1, 511, 17, 0, 256};
        int p, w, h;
        for (p = 0; p < 12; p++)
        begin
            if (p < 6)
                set_grid_config(ext_r[p], ext_w[p], ext_h[p]);
            else
            begin
                case ($urandom_range(0, 3))
                    0: w = $urandom_range(257, 511);
                    1: w = $urandom_range(1, 16);
                    default: w = $urandom_range(1, 256);
                endcase
                case ($urandom_range(0, 3))
                    0: h = $urandom_range(257, 511);
                    1: h = $urandom_range(1, 16);
                    default: h = $urandom_range(1, 256);
                endcase
                set_grid_config($urandom_range(0, 7), w, h);
            end
            run_random_items(110);
        end
    endtask

    // sender holds off until every pending response is back, then resumes
    task automatic test_drain_pause;
        set_grid_config(4, 64, 64);
        run_random_items(20);
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        run_random_items(20);
    endtask

    task automatic test_back_to_back;
        bursts_on = 1'b0;
        set_grid_config(4, 48, 40);
        run_random_items(150);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        bursts_on       = 1'b1;
        req_ch.valid    = 1'b0;
        req_ch.op       = ogi_pkg::OP_WRITE;
        req_ch.cell_x   = '0;
        req_ch.cell_y   = '0;
        req_ch.occupied = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = ogi_pkg::CFG_RADIUS;
        cfg_ch.data     = '0;
        cfg_radius      = ogi_pkg::RADIUS_RST;
        cfg_width       = ogi_pkg::GRID_WIDTH_RST;
        cfg_height      = ogi_pkg::GRID_HEIGHT_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_window();
        test_config_extremes();
        test_random_settings();
        test_drain_pause();
        test_back_to_back();
        settle_block();

        $display("covered %0d writes and %0d queries over %0d grid settings",
                 writes_sent, queries_sent, settings_used);
        $display("checked %0d responses: %0d inflated, %0d off grid, %0d errors",
                 answers_checked, hits_seen, flags_seen, error_count);
        if (error_count == 0 && pending_answers.size() == 0)
            $display("occupancy_grid_inflation test passed");
        else
            $display("occupancy_grid_inflation test failed");
        $finish;
    end

endmodule
